FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/c3gsf_pkg.sv
// ----------------------------------------------------------------------------
// c3gsf_pkg
// constants and types of the 3x3 gaussian / sobel filter unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c3gsf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int ROW_W     = 12;
    localparam int PEND_W    = 11;
    localparam int CFG_W     = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_CAP    = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_CAP   = HEIGHT_W'(4096);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // reciprocals scaled by 2^RECIP_SHIFT, exact for the sum ranges used
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_1  = RECIP_W'(65536);
    localparam logic [RECIP_W-1:0] RECIP_3  = RECIP_W'(21846);
    localparam logic [RECIP_W-1:0] RECIP_4  = RECIP_W'(16384);
    localparam logic [RECIP_W-1:0] RECIP_9  = RECIP_W'(7282);
    localparam logic [RECIP_W-1:0] RECIP_12 = RECIP_W'(5462);
    localparam logic [RECIP_W-1:0] RECIP_16 = RECIP_W'(4096);

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;
    localparam logic MODE_GAUSS   = 1'b0;
    localparam logic MODE_SOBEL   = 1'b1;

    typedef enum logic [1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAP  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

FILE: hdl/conv3x3_gaussian_sobel_filter_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_gaussian_sobel_filter_unit
// flow: a releasing transaction passes the tap, sum, divide and out states in
//   order, a pixel with no result only the tap state, an ignored flush none;
//   s_ready is high only in idle, and out waits until a held result is taken
// reset: synchronous active low, counters and taps cleared, line stores kept
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module conv3x3_gaussian_sobel_filter_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [c3gsf_pkg::CFG_W-1:0]  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [7:0]                   s_pixel_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_pixel_out,
    output logic                         m_last_of_frame
);

    import c3gsf_pkg::*;

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [7:0] upper_mem [MAX_WIDTH];
    logic [7:0] lower_mem [MAX_WIDTH];
    logic [7:0] upper_rd_reg, lower_rd_reg;
    logic [COL_W-1:0] rd_addr;
    logic lower_we, upper_we;

    logic [COL_W-1:0] addr_reg;
    logic             action_reg;
    logic [7:0]       pixel_reg;
    logic             emit_reg;
    logic             left_reg, right_reg, top_reg, bottom_reg, last_reg;

    logic [7:0] tap_reg [9];

    logic [11:0]        g_sum_reg;
    logic [9:0]         h_abs_reg, v_abs_reg;
    logic [RECIP_W-1:0] g_recip_reg, h_recip_reg, v_recip_reg;
    logic [7:0]         g_q_reg;
    logic [9:0]         h_q_reg, v_q_reg;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_pixel_out_reg;
    logic       m_last_reg;

    // position and pending bookkeeping
    logic accept, at_start, pend_nz, tail_drop, pixel_emit, flush_emit, emit_now;
    logic [WIDTH_W-1:0]  w_plus1, oc_inc, ic_inc;
    logic [HEIGHT_W-1:0] or_inc, ir_inc;
    logic [COL_W-1:0]    oc_cur, vc;
    logic [ROW_W-1:0]    or_cur;
    logic [PEND_W-1:0]   pend_base, pend_inc;
    logic oc_wrap, or_wrap, ic_wrap, ir_wrap;
    logic cfg_hit;

    assign accept   = s_valid && s_ready;
    assign at_start = (in_col_reg == '0) && (in_row_reg == '0);
    assign pend_nz  = (pend_reg != '0);
    assign w_plus1  = width_reg + WIDTH_W'(1);

    assign tail_drop  = (s_action == ACTION_PIXEL) && at_start && pend_nz
                        && (pend_reg < w_plus1);
    assign oc_cur     = tail_drop ? '0 : out_col_reg;
    assign or_cur     = tail_drop ? '0 : out_row_reg;
    assign pend_base  = tail_drop ? '0 : pend_reg;
    assign pend_inc   = pend_base + PEND_W'(1);
    assign pixel_emit = (pend_inc > w_plus1);
    assign flush_emit = at_start && pend_nz;
    assign emit_now   = (s_action == ACTION_PIXEL) ? pixel_emit : flush_emit;

    assign oc_inc  = WIDTH_W'(oc_cur) + WIDTH_W'(1);
    assign oc_wrap = (oc_inc >= width_reg);
    assign or_inc  = HEIGHT_W'(or_cur) + HEIGHT_W'(1);
    assign or_wrap = (or_inc >= height_reg);
    assign vc      = oc_wrap ? '0 : oc_inc[COL_W-1:0];

    assign ic_inc  = WIDTH_W'(in_col_reg) + WIDTH_W'(1);
    assign ic_wrap = (ic_inc >= width_reg);
    assign ir_inc  = HEIGHT_W'(in_row_reg) + HEIGHT_W'(1);
    assign ir_wrap = (ir_inc >= height_reg);

    assign rd_addr = (s_action == ACTION_PIXEL) ? in_col_reg : vc;

    assign cfg_hit = cfg_wr_en && ((cfg_index == CFG_FILTER_MODE)
                     || (cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

    always_comb begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACTION_PIXEL) begin
                        state_next   = ST_TAP;
                        in_col_next  = ic_wrap ? '0 : ic_inc[COL_W-1:0];
                        in_row_next  = ic_wrap ? (ir_wrap ? '0 : ir_inc[ROW_W-1:0])
                                               : in_row_reg;
                        pend_next    = pixel_emit ? w_plus1 : pend_inc;
                        out_col_next = oc_cur;
                        out_row_next = or_cur;
                    end else if (flush_emit) begin
                        state_next = ST_TAP;
                        pend_next  = pend_reg - PEND_W'(1);
                    end
                    if (emit_now) begin
                        out_col_next = vc;
                        out_row_next = oc_wrap ? (or_wrap ? '0 : or_inc[ROW_W-1:0])
                                               : or_cur;
                    end
                end
            end
            ST_TAP: begin
                state_next = emit_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_hit) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_GAUSS;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FILTER_MODE: begin
                        mode_reg <= cfg_data[0];
                    end
                    CFG_FRAME_WIDTH: begin
                        if (cfg_data[WIDTH_W-1:0] < WIDTH_MIN) begin
                            width_reg <= WIDTH_MIN;
                        end else if (cfg_data[WIDTH_W-1:0] > WIDTH_CAP) begin
                            width_reg <= WIDTH_CAP;
                        end else begin
                            width_reg <= cfg_data[WIDTH_W-1:0];
                        end
                    end
                    CFG_FRAME_HEIGHT: begin
                        if (cfg_data[HEIGHT_W-1:0] < HEIGHT_MIN) begin
                            height_reg <= HEIGHT_MIN;
                        end else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_CAP) begin
                            height_reg <= HEIGHT_CAP;
                        end else begin
                            height_reg <= cfg_data[HEIGHT_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // line stores: read at accept, lower written then, upper written back next cycle
    assign lower_we = accept && (s_action == ACTION_PIXEL);
    assign upper_we = (state_reg == ST_TAP) && (action_reg == ACTION_PIXEL);

    always_ff @(posedge aclk) begin
        if (accept) begin
            lower_rd_reg <= lower_mem[rd_addr];
        end
        if (lower_we) begin
            lower_mem[rd_addr] <= s_pixel_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            upper_rd_reg <= upper_mem[rd_addr];
        end
        if (upper_we) begin
            upper_mem[addr_reg] <= lower_rd_reg;
        end
    end

    // transaction context captured at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg   <= rd_addr;
            action_reg <= s_action;
            pixel_reg  <= s_pixel_in;
            emit_reg   <= emit_now;
            left_reg   <= (oc_cur == '0);
            right_reg  <= (WIDTH_W'(oc_cur) == width_reg - WIDTH_W'(1));
            top_reg    <= (or_cur == '0);
            bottom_reg <= (HEIGHT_W'(or_cur) == height_reg - HEIGHT_W'(1));
            last_reg   <= (WIDTH_W'(oc_cur) == width_reg - WIDTH_W'(1))
                          && (HEIGHT_W'(or_cur) == height_reg - HEIGHT_W'(1));
        end
    end

    // tap window, index column*3 + row, column 2 newest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (state_reg == ST_TAP) begin
            for (int i = 0; i < 6; i++) begin
                tap_reg[i] <= tap_reg[i+3];
            end
            tap_reg[6] <= upper_rd_reg;
            tap_reg[7] <= lower_rd_reg;
            tap_reg[8] <= (action_reg == ACTION_PIXEL) ? pixel_reg : 8'd0;
        end
    end

    // masked sums
    logic [2:0]  col_ok, row_ok;
    logic [11:0] tx [9];
    logic [11:0] g_sum, right_col, left_col, bot_row, top_row, h_diff, v_diff;
    logic        x_edge, y_edge;

    assign col_ok = {!right_reg, 1'b1, !left_reg};
    assign row_ok = {!bottom_reg, 1'b1, !top_reg};
    assign x_edge = left_reg || right_reg;
    assign y_edge = top_reg || bottom_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                tx[c*3+r] = (col_ok[c] && row_ok[r]) ? {4'd0, tap_reg[c*3+r]} : 12'd0;
            end
        end
    end

    assign g_sum = tx[0] + (tx[1] << 1) + tx[2]
                 + (tx[3] << 1) + (tx[4] << 2) + (tx[5] << 1)
                 + tx[6] + (tx[7] << 1) + tx[8];
    assign right_col = tx[6] + (tx[7] << 1) + tx[8];
    assign left_col  = tx[0] + (tx[1] << 1) + tx[2];
    assign bot_row   = tx[2] + (tx[5] << 1) + tx[8];
    assign top_row   = tx[0] + (tx[3] << 1) + tx[6];
    assign h_diff    = (right_col >= left_col) ? right_col - left_col : left_col - right_col;
    assign v_diff    = (bot_row >= top_row) ? bot_row - top_row : top_row - bot_row;

    always_ff @(posedge aclk) begin
        g_sum_reg   <= g_sum;
        h_abs_reg   <= h_diff[9:0];
        v_abs_reg   <= v_diff[9:0];
        g_recip_reg <= (x_edge && y_edge) ? RECIP_9 : ((x_edge || y_edge) ? RECIP_12 : RECIP_16);
        h_recip_reg <= x_edge ? (y_edge ? RECIP_3 : RECIP_4) : RECIP_1;
        v_recip_reg <= y_edge ? (x_edge ? RECIP_3 : RECIP_4) : RECIP_1;
    end

    // division by the in-bounds weight sum, or by one where that sum is zero
    logic [28:0] g_prod;
    logic [26:0] h_prod, v_prod;

    assign g_prod = 29'(g_sum_reg) * 29'(g_recip_reg);
    assign h_prod = 27'(h_abs_reg) * 27'(h_recip_reg);
    assign v_prod = 27'(v_abs_reg) * 27'(v_recip_reg);

    always_ff @(posedge aclk) begin
        g_q_reg <= g_prod[RECIP_SHIFT +: 8];
        h_q_reg <= h_prod[RECIP_SHIFT +: 10];
        v_q_reg <= v_prod[RECIP_SHIFT +: 10];
    end

    // output register
    logic [10:0] sob_sum;
    logic [7:0]  sob_sat, result;
    logic        out_load;

    assign sob_sum  = {1'b0, h_q_reg} + {1'b0, v_q_reg};
    assign sob_sat  = (sob_sum[10:1] > 10'd255) ? 8'hFF : sob_sum[8:1];
    assign result   = (mode_reg == MODE_SOBEL) ? sob_sat : g_q_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_out_reg <= result;
            m_last_reg      <= last_reg;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = m_pixel_out_reg;
    assign m_last_of_frame = m_last_reg;

    `ASSERT_CLK(a_pend_bound, (pend_reg <= w_plus1), "pending count above width plus one")
    `ASSERT_CLK(a_out_pos_bound, ((WIDTH_W'(out_col_reg) < width_reg) && (HEIGHT_W'(out_row_reg) < height_reg)), "output position outside frame")
    `ASSERT_CLK(a_in_pos_bound, ((WIDTH_W'(in_col_reg) < width_reg) && (HEIGHT_W'(in_row_reg) < height_reg)), "input position outside frame")
    `ASSERT_NEXT(a_pixel_to_tap, (accept && (s_action == ACTION_PIXEL)), (state_reg == ST_TAP), "pixel transaction did not reach tap update")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for conv3x3_gaussian_sobel_filter_unit
// streams raster frames, flush ticks and register writes into the filter and
// checks every output transaction against a cycle-free model of the window,
// line stores and raster counters kept in a small scoreboard class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import c3gsf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 60;
    localparam int FRAME_CAP     = 120;

    typedef struct packed {
        logic [7:0] pixel;
        logic       eof;
    } filtered_t;

    class conv_scoreboard;
        int               gauss_k[3][3];
        int               sobel_h[3][3];
        int               sobel_v[3][3];
        logic             mode_reg;
        logic [10:0]      width_reg;
        logic [12:0]      height_reg;
        logic [7:0]       upper_line[MAX_WIDTH];
        logic [7:0]       lower_line[MAX_WIDTH];
        logic [7:0]       taps[9];
        int               in_col, in_row, out_col, out_row, owed;
        filtered_t        expected_q[$];
        int               mismatches;

        function new();
            gauss_k = '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}};
            sobel_h = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
            sobel_v = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
            mismatches = 0;
            mode_reg   = MODE_GAUSS;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_line[i]) begin
                upper_line[i] = 8'h00;
                lower_line[i] = 8'h00;
            end
            foreach (taps[i]) taps[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            owed    = 0;
        endfunction

        function int frame_w();
            int w;
            w = width_reg;
            if (w < WIDTH_MIN) w = WIDTH_MIN;
            if (w > WIDTH_CAP) w = WIDTH_CAP;
            return w;
        endfunction

        function int frame_h();
            int h;
            h = height_reg;
            if (h < HEIGHT_MIN) h = HEIGHT_MIN;
            if (h > HEIGHT_CAP) h = HEIGHT_CAP;
            return h;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_FILTER_MODE:  mode_reg = value[0];
                CFG_FRAME_WIDTH:  width_reg = value[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = value[HEIGHT_W-1:0];
                default: return;
            endcase
            restart();
        endfunction

        function void step_pos(inout int col, inout int row);
            col++;
            if (col >= frame_w()) begin
                col = 0;
                row++;
                if (row >= frame_h()) row = 0;
            end
        endfunction

        function void shift_taps(logic [7:0] top, logic [7:0] mid, logic [7:0] bot);
            for (int i = 0; i < 6; i++) taps[i] = taps[i + 3];
            taps[6] = top;
            taps[7] = mid;
            taps[8] = bot;
        endfunction

        // weighted sum over in-frame taps, divided by the in-frame weight sum when nonzero
        function int kernel_response(input int k[3][3]);
            int acc, wsum, x, y, v;
            acc  = 0;
            wsum = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    x = out_col + dx;
                    y = out_row + dy;
                    if (x >= 0 && x < frame_w() && y >= 0 && y < frame_h()) begin
                        v = taps[(dx + 1) * 3 + (dy + 1)];
                        acc  += v * k[dy + 1][dx + 1];
                        wsum += k[dy + 1][dx + 1];
                    end
                end
            end
            return (wsum != 0) ? acc / wsum : acc;
        endfunction

        function void emit_pixel();
            int        a, b, r;
            filtered_t item;
            if (mode_reg == MODE_SOBEL) begin
                a = kernel_response(sobel_h);
                b = kernel_response(sobel_v);
                if (a < 0) a = -a;
                if (b < 0) b = -b;
                r = (a + b) / 2;
            end else begin
                r = kernel_response(gauss_k);
            end
            if (r < 0) r = 0;
            if (r > 255) r = 255;
            item.pixel = r[7:0];
            item.eof   = (out_col == frame_w() - 1 && out_row == frame_h() - 1);
            expected_q.insert(expected_q.size(), item);
            step_pos(out_col, out_row);
            if (owed > 0) owed--;
        endfunction

        function void accept_item(logic act, logic [7:0] pix);
            int         w, c, vc;
            logic       at_start;
            logic [7:0] top, mid;
            w = frame_w();
            at_start = (in_col == 0 && in_row == 0);
            if (act == ACTION_FLUSH) begin
                if (at_start && owed > 0) begin
                    vc = out_col + 1;
                    if (vc >= w) vc = 0;
                    shift_taps(upper_line[vc], lower_line[vc], 8'h00);
                    emit_pixel();
                end
            end else begin
                // new pixel after a partial drain drops the old tail
                if (at_start && owed > 0 && owed < w + 1) begin
                    owed    = 0;
                    out_col = 0;
                    out_row = 0;
                end
                c   = in_col;
                top = upper_line[c];
                mid = lower_line[c];
                upper_line[c] = mid;
                lower_line[c] = pix;
                shift_taps(top, mid, pix);
                step_pos(in_col, in_row);
                owed++;
                if (owed > w + 1) begin
                    emit_pixel();
                    owed = w + 1;
                end
            end
        endfunction

        function void compare_pixel(logic [7:0] pix, logic eof);
            filtered_t exp_item;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction: pixel %0d eof %0b", pix, eof);
                return;
            end
            exp_item = expected_q.pop_front();
            if (pix !== exp_item.pixel || eof !== exp_item.eof) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output mismatch: expected pixel %0d eof %0b, got pixel %0d eof %0b",
                             exp_item.pixel, exp_item.eof, pix, eof);
            end
        endfunction
    endclass

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    cfg_index_t           cfg_index       = CFG_FILTER_MODE;
    logic [CFG_W-1:0]     cfg_data        = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_action        = ACTION_PIXEL;
    logic [7:0]           s_pixel_in      = 8'h00;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [7:0]           m_pixel_out;
    logic                 m_last_of_frame;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int cycle_count  = 0;

    conv_scoreboard board = new();

    logic [7:0] probe_px [18] = '{8'h00, 8'hff, 8'h80, 8'hff, 8'h00,
                                  8'h01, 8'hfe, 8'haa, 8'h55,
                                  8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                                  8'h00, 8'hff, 8'h00, 8'h7f};

    conv3x3_gaussian_sobel_filter_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_valid && m_ready)
            board.compare_pixel(m_pixel_out, m_last_of_frame);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] make_pixel(int style);
        case (style)
            0:       return 8'($urandom_range(0, 255));
            1:       return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            default: return 8'(120 + $urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [7:0] pix);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        board.accept_item(act, pix);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes all three registers back to back while the stream is idle
    task automatic configure(input logic mode, input logic [CFG_W-1:0] width,
                             input logic [CFG_W-1:0] height);
        drain_outputs();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FILTER_MODE;
        cfg_data  <= CFG_W'(mode);
        board.write_reg(CFG_FILTER_MODE, CFG_W'(mode));
        @(posedge aclk);
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= width;
        board.write_reg(CFG_FRAME_WIDTH, width);
        @(posedge aclk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= height;
        board.write_reg(CFG_FRAME_HEIGHT, height);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int               w, h, len, noise_at, style, tail, sent;
        logic             mode;
        logic [CFG_W-1:0] width_val, height_val;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest frame, width and height written below their minimum
        configure(MODE_GAUSS, CFG_W'(2), CFG_W'(0));
        send_item(ACTION_FLUSH, 8'hff);
        for (int i = 0; i < 5; i++) send_item(ACTION_PIXEL, probe_px[i]);
        send_item(ACTION_FLUSH, 8'h00);
        for (int i = 5; i < 9; i++) send_item(ACTION_PIXEL, probe_px[i]);
        repeat (2) send_item(ACTION_FLUSH, 8'h00);
        // fresh frame after a partial drain
        for (int i = 9; i < 18; i++) send_item(ACTION_PIXEL, probe_px[i]);
        repeat (4) send_item(ACTION_FLUSH, 8'hff);

        for (int p = 0; p < 12; p++) begin
            drain_outputs();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            mode       = (p < 2) ? logic'(p) : logic'($urandom_range(0, 1));
            width_val  = CFG_W'($urandom_range(3, 9));
            height_val = CFG_W'($urandom_range(3, 5));
            case (p)
                2:  width_val = CFG_W'(0);
                5:  begin width_val = CFG_W'(3); height_val = CFG_W'(8191); end
                7:  height_val = CFG_W'(2);
                9:  begin width_val = CFG_W'(1); height_val = CFG_W'(1); end
                10: width_val = CFG_W'(24);
                default: ;
            endcase
            configure(mode, width_val, height_val);
            if (p == 4) rx_hold_left = 400;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                w   = board.frame_w();
                h   = board.frame_h();
                len = (w * h > FRAME_CAP) ? FRAME_CAP : w * h;
                style = $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len - 1);
                noise_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
                for (int i = 0; i < len; i++) begin
                    if (i == noise_at) send_item(ACTION_FLUSH, make_pixel(0));
                    send_item(ACTION_PIXEL, make_pixel(style));
                    sent++;
                end
                case ($urandom_range(0, 4))
                    0, 1: tail = 0;
                    2, 3: tail = w + 1 + (($urandom_range(0, 3) == 0) ? 1 : 0);
                    default: tail = $urandom_range(1, w);
                endcase
                repeat (tail) begin
                    send_item(ACTION_FLUSH, make_pixel(0));
                    sent++;
                end
            end
        end

        drain_outputs();
        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/c3gsf_pkg.sv
hdl/conv3x3_gaussian_sobel_filter_unit.sv
dv/testbench.sv
